// ===== hdl/odo_pkg.sv =====
`timescale 1ns / 1ps

package odo_pkg;

  // Register map, one 16-bit register per 32-bit word.
  localparam int unsigned REG_ADDR_W = 4;
  localparam logic [1:0] REG_WHEEL_RADIUS = 2'd0;
  localparam logic [1:0] REG_HALF_TRACK   = 2'd1;
  localparam logic [1:0] REG_TIME_STEP    = 2'd2;

  localparam logic [15:0] WHEEL_RADIUS_RST = 16'd2294;
  localparam logic [15:0] HALF_TRACK_RST   = 16'd4915;
  localparam logic [15:0] TIME_STEP_RST    = 16'd655;

  localparam int unsigned CORDIC_STEPS_DEF = 16;
  localparam int unsigned ATAN_LEN         = 30;
  localparam int unsigned ATAN_IDX_W       = 5;
  localparam logic signed [31:0] CORDIC_GAIN = 32'sd652032874;
  localparam logic [29:0] INV_TWO_PI         = 30'd683565276;

  // Turn-rate divider: 58-bit dividend, two quotient bits per cycle.
  localparam int unsigned DIV_W = 58;
  localparam logic [4:0] DIV_CYCLES = 5'd29;

  typedef struct packed {
    logic [15:0] wheel_radius;
    logic [15:0] half_track;
    logic [15:0] time_step;
  } odo_cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL_A,
    ST_MUL_B,
    ST_PREP,
    ST_DIV,
    ST_PROD,
    ST_SUM,
    ST_STEP,
    ST_UPD,
    ST_EMIT
  } odo_state_t;

  typedef struct packed {
    logic load;
    logic mul_a;
    logic mul_b;
    logic prep;
    logic prod;
    logic sum;
    logic step;
    logic upd;
    logic emit;
  } odo_cmd_t;

  typedef struct packed {
    logic cordic_busy;
    logic div_busy;
  } odo_status_t;

  // atan(2^-i) as a binary angle, 2^32 to the turn.
  function automatic logic signed [31:0] atan_lut(input logic [ATAN_IDX_W-1:0] idx);
    logic signed [31:0] v;
    case (idx)
      5'd0:  v = 32'sd536870912;
      5'd1:  v = 32'sd316933406;
      5'd2:  v = 32'sd167458907;
      5'd3:  v = 32'sd85004756;
      5'd4:  v = 32'sd42667331;
      5'd5:  v = 32'sd21354465;
      5'd6:  v = 32'sd10679838;
      5'd7:  v = 32'sd5340245;
      5'd8:  v = 32'sd2670163;
      5'd9:  v = 32'sd1335087;
      5'd10: v = 32'sd667544;
      5'd11: v = 32'sd333772;
      5'd12: v = 32'sd166886;
      5'd13: v = 32'sd83443;
      5'd14: v = 32'sd41722;
      5'd15: v = 32'sd20861;
      5'd16: v = 32'sd10430;
      5'd17: v = 32'sd5215;
      5'd18: v = 32'sd2608;
      5'd19: v = 32'sd1304;
      5'd20: v = 32'sd652;
      5'd21: v = 32'sd326;
      5'd22: v = 32'sd163;
      5'd23: v = 32'sd81;
      5'd24: v = 32'sd41;
      5'd25: v = 32'sd20;
      5'd26: v = 32'sd10;
      5'd27: v = 32'sd5;
      5'd28: v = 32'sd3;
      5'd29: v = 32'sd1;
      default: v = 32'sd0;
    endcase
    return v;
  endfunction

endpackage

// ===== hdl/odo_in_if.sv =====
`timescale 1ns / 1ps

interface odo_in_if;
  logic valid;
  logic ready;
  logic signed [15:0] left_speed;
  logic signed [15:0] right_speed;

  modport source (output valid, output left_speed, output right_speed, input ready);
  modport sink (input valid, input left_speed, input right_speed, output ready);
endinterface

// ===== hdl/odo_out_if.sv =====
`timescale 1ns / 1ps

interface odo_out_if;
  logic valid;
  logic ready;
  logic signed [31:0] pos_x;
  logic signed [31:0] pos_y;
  logic signed [31:0] heading;

  modport source (output valid, output pos_x, output pos_y, output heading, input ready);
  modport sink (input valid, input pos_x, input pos_y, input heading, output ready);
endinterface

// ===== hdl/odo_regs.sv =====
`timescale 1ns / 1ps

module odo_regs import odo_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [REG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready,
  output odo_cfg_t              cfg
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.wheel_radius <= WHEEL_RADIUS_RST;
      cfg.half_track   <= HALF_TRACK_RST;
      cfg.time_step    <= TIME_STEP_RST;
    end else if (wr_en) begin
      unique case (paddr[3:2])
        REG_WHEEL_RADIUS: cfg.wheel_radius <= pwdata[15:0];
        REG_HALF_TRACK:   cfg.half_track   <= pwdata[15:0];
        REG_TIME_STEP:    cfg.time_step    <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_WHEEL_RADIUS: prdata = {16'd0, cfg.wheel_radius};
      REG_HALF_TRACK:   prdata = {16'd0, cfg.half_track};
      REG_TIME_STEP:    prdata = {16'd0, cfg.time_step};
      default:          prdata = 32'd0;
    endcase
  end

endmodule

// ===== hdl/odo_cordic.sv =====
`timescale 1ns / 1ps

module odo_cordic import odo_pkg::*; #(
  parameter int unsigned CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [31:0]        angle,
  output logic signed [31:0] cos_val,
  output logic signed [31:0] sin_val,
  output logic               busy
);

  localparam int unsigned CntW = $clog2(CORDIC_STEPS + 1);
  localparam logic [CntW-1:0] LastCnt = CntW'(CORDIC_STEPS);

  logic [CntW-1:0]    cnt;
  logic signed [31:0] cx;
  logic signed [31:0] cy;
  logic signed [31:0] cz;
  logic               neg;
  logic signed [31:0] xs;
  logic signed [31:0] ys;
  logic signed [31:0] ang_step;

  assign busy     = (cnt != LastCnt);
  assign xs       = cx >>> cnt;
  assign ys       = cy >>> cnt;
  assign ang_step = atan_lut(ATAN_IDX_W'(cnt));

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= LastCnt;
    end else if (start) begin
      cnt <= '0;
    end else if (busy) begin
      cnt <= cnt + 1'b1;
    end
  end

  // Beyond a quarter turn either way the angle is moved by half a turn, which
  // on a 32-bit binary angle is a flip of the top bit; the results are negated.
  always_ff @(posedge clk) begin
    if (start) begin
      cx  <= CORDIC_GAIN;
      cy  <= '0;
      if (($signed(angle) > 32'sh4000_0000) || ($signed(angle) < -32'sh4000_0000)) begin
        cz  <= {~angle[31], angle[30:0]};
        neg <= 1'b1;
      end else begin
        cz  <= angle;
        neg <= 1'b0;
      end
    end else if (busy) begin
      if (!cz[31]) begin
        cx <= cx - ys;
        cy <= cy + xs;
        cz <= cz - ang_step;
      end else begin
        cx <= cx + ys;
        cy <= cy - xs;
        cz <= cz + ang_step;
      end
    end
  end

  assign cos_val = neg ? -cx : cx;
  assign sin_val = neg ? -cy : cy;

endmodule

// ===== hdl/odo_dp.sv =====
`timescale 1ns / 1ps

module odo_dp import odo_pkg::*; #(
  parameter int unsigned CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  odo_cmd_t           cmd,
  output odo_status_t        status,
  input  odo_cfg_t           cfg,
  input  logic signed [15:0] left_speed,
  input  logic signed [15:0] right_speed,
  output logic signed [31:0] pos_x,
  output logic signed [31:0] pos_y,
  output logic signed [31:0] heading
);

  localparam logic [65:0] DxHalf = 66'd1 << 37;

  logic signed [16:0] sum_w;
  logic signed [16:0] diff_w;
  logic signed [33:0] a_r;
  logic signed [33:0] b_r;
  logic signed [50:0] ad;
  logic signed [50:0] bd;
  logic signed [33:0] d;
  logic               qneg;
  logic [DIV_W-1:0]   div_q;
  logic [16:0]        div_rem;
  logic [4:0]         div_cnt;
  logic signed [48:0] pxl;
  logic signed [48:0] pyl;
  logic signed [49:0] pxh;
  logic signed [49:0] pyh;
  logic [61:0]        plo;
  logic [31:0]        phi;
  logic [65:0]        dxf;
  logic [65:0]        dyf;
  logic [63:0]        pprod;
  logic [27:0]        dx;
  logic [27:0]        dy;
  logic [31:0]        hstep;
  logic [31:0]        x_pos;
  logic [31:0]        y_pos;
  logic [31:0]        h_ang;

  logic signed [31:0] cos_v;
  logic signed [31:0] sin_v;
  logic               cordic_busy;

  logic signed [50:0] ad_rnd;
  logic [50:0]        b_abs;
  logic [16:0]        den;
  logic [17:0]        t1;
  logic [17:0]        t2;
  logic               qb1;
  logic               qb2;
  logic [16:0]        r1;
  logic [16:0]        r2;
  logic [65:0]        dx_rnd;
  logic [65:0]        dy_rnd;
  logic [63:0]        h_rnd;

  function automatic logic [31:0] sat_add(input logic [31:0] base, input logic [27:0] dlt);
    logic [32:0] s;
    s = {base[31], base} + {{5{dlt[27]}}, dlt};
    if (s[32] != s[31]) begin
      return s[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
    end
    return s[31:0];
  endfunction

  odo_cordic #(.CORDIC_STEPS(CORDIC_STEPS)) u_cordic (
    .clk     (clk),
    .rst     (rst),
    .start   (cmd.load),
    .angle   (h_ang),
    .cos_val (cos_v),
    .sin_val (sin_v),
    .busy    (cordic_busy)
  );

  assign status.cordic_busy = cordic_busy;
  assign status.div_busy    = (div_cnt != 5'd0);

  // The negative dividend uses ~bd = |bd| - 1, so the missing one (scaled by
  // 256) joins the rounding term in the same adder.
  assign ad_rnd = ad + 51'sd65536;
  assign b_abs  = bd[50] ? ~bd : bd;
  assign den    = {cfg.half_track, 1'b0};

  // Two restoring division steps per cycle.
  always_comb begin
    t1  = {div_rem, div_q[DIV_W-1]};
    qb1 = (t1 >= {1'b0, den});
    r1  = qb1 ? 17'(t1 - {1'b0, den}) : t1[16:0];
    t2  = {r1, div_q[DIV_W-2]};
    qb2 = (t2 >= {1'b0, den});
    r2  = qb2 ? 17'(t2 - {1'b0, den}) : t2[16:0];
  end

  assign dx_rnd = dxf + DxHalf;
  assign dy_rnd = dyf + DxHalf;
  assign h_rnd  = qneg ? (~pprod + 64'h8000_0001) : (pprod + 64'h8000_0000);

  always_ff @(posedge clk) begin
    if (rst) begin
      div_cnt <= 5'd0;
    end else if (cmd.prep) begin
      div_cnt <= DIV_CYCLES;
    end else if (div_cnt != 5'd0) begin
      div_cnt <= div_cnt - 5'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.prep) begin
      div_q   <= {1'b0, b_abs[48:0], 8'd0}
                 + (bd[50] ? (DIV_W'(cfg.half_track) + DIV_W'(256))
                           : DIV_W'(cfg.half_track));
      div_rem <= '0;
    end else if (div_cnt != 5'd0) begin
      div_q   <= {div_q[DIV_W-3:0], qb1, qb2};
      div_rem <= r2;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sum_w  <= {left_speed[15], left_speed} + {right_speed[15], right_speed};
      diff_w <= {right_speed[15], right_speed} - {left_speed[15], left_speed};
    end
    if (cmd.mul_a) begin
      a_r <= $signed({1'b0, cfg.wheel_radius}) * sum_w;
      b_r <= $signed({1'b0, cfg.wheel_radius}) * diff_w;
    end
    if (cmd.mul_b) begin
      ad <= a_r * $signed({1'b0, cfg.time_step});
      bd <= b_r * $signed({1'b0, cfg.time_step});
    end
    if (cmd.prep) begin
      d    <= ad_rnd[50:17];
      qneg <= bd[50];
    end
    if (cmd.prod) begin
      pxl <= $signed({1'b0, d[15:0]}) * cos_v;
      pyl <= $signed({1'b0, d[15:0]}) * sin_v;
      pxh <= $signed(d[33:16]) * cos_v;
      pyh <= $signed(d[33:16]) * sin_v;
      plo <= {30'd0, div_q[31:0]} * {32'd0, INV_TWO_PI};
      phi <= {6'd0, div_q[DIV_W-1:32]} * {2'd0, INV_TWO_PI};
    end
    if (cmd.sum) begin
      dxf   <= {pxh, 16'd0} + {{17{pxl[48]}}, pxl};
      dyf   <= {pyh, 16'd0} + {{17{pyl[48]}}, pyl};
      pprod <= {2'd0, plo} + {phi, 32'd0};
    end
    if (cmd.step) begin
      dx    <= dx_rnd[65:38];
      dy    <= dy_rnd[65:38];
      hstep <= h_rnd[63:32];
    end
    if (cmd.emit) begin
      pos_x   <= x_pos;
      pos_y   <= y_pos;
      heading <= h_ang;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      x_pos <= '0;
      y_pos <= '0;
      h_ang <= '0;
    end else if (cmd.upd) begin
      x_pos <= sat_add(x_pos, dx);
      y_pos <= sat_add(y_pos, dy);
      // A zero half track means no turn at all.
      if (cfg.half_track != 16'd0) begin
        h_ang <= h_ang + hstep;
      end
    end
  end

endmodule

// ===== hdl/odo_ctrl.sv =====
`timescale 1ns / 1ps

module odo_ctrl import odo_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  output logic        out_valid,
  input  logic        out_ready,
  input  odo_status_t status,
  output odo_cmd_t    cmd
);

  odo_state_t state;
  odo_state_t state_next;
  logic       out_valid_next;
  logic       slot_free;

  assign slot_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (in_valid) state_next = ST_MUL_A;
      ST_MUL_A: state_next = ST_MUL_B;
      ST_MUL_B: state_next = ST_PREP;
      ST_PREP:  state_next = ST_DIV;
      ST_DIV: begin
        if (!status.div_busy && !status.cordic_busy) state_next = ST_PROD;
      end
      ST_PROD:  state_next = ST_SUM;
      ST_SUM:   state_next = ST_STEP;
      ST_STEP:  state_next = ST_UPD;
      ST_UPD:   state_next = ST_EMIT;
      ST_EMIT:  if (slot_free) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_MUL_A: cmd.mul_a = 1'b1;
      ST_MUL_B: cmd.mul_b = 1'b1;
      ST_PREP:  cmd.prep  = 1'b1;
      ST_DIV:   ;
      ST_PROD:  cmd.prod  = 1'b1;
      ST_SUM:   cmd.sum   = 1'b1;
      ST_STEP:  cmd.step  = 1'b1;
      ST_UPD:   cmd.upd   = 1'b1;
      ST_EMIT:  cmd.emit  = slot_free;
      default:  ;
    endcase
  end

  always_comb begin
    if (cmd.emit) begin
      out_valid_next = 1'b1;
    end else if (out_ready) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

endmodule

// ===== hdl/differential_drive_odometry_top.sv =====
`timescale 1ns / 1ps
// An accepted item goes through MUL_A, MUL_B, PREP, DIV (held until the divider
// and CORDIC are idle), PROD, SUM, STEP, UPD and EMIT; the next item is taken
// once the result has moved into the output register. The turn-rate divider, two
// quotient bits per cycle, outlasts the default CORDIC, which runs alongside it.
// Reset (rst, synchronous) zeroes the pose, loads the register defaults and idles.

module differential_drive_odometry_top import odo_pkg::*; #(
  parameter int unsigned CORDIC_STEPS = CORDIC_STEPS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  odo_in_if.sink                in_ch,
  odo_out_if.source             out_ch,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [REG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  odo_cfg_t    cfg;
  odo_cmd_t    ctrl_cmd;
  odo_status_t dp_status;

  odo_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  odo_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .status    (dp_status),
    .cmd       (ctrl_cmd)
  );

  odo_dp #(.CORDIC_STEPS(CORDIC_STEPS)) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (ctrl_cmd),
    .status      (dp_status),
    .cfg         (cfg),
    .left_speed  (in_ch.left_speed),
    .right_speed (in_ch.right_speed),
    .pos_x       (out_ch.pos_x),
    .pos_y       (out_ch.pos_y),
    .heading     (out_ch.heading)
  );

  // Only one item is in flight at a time.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("input taken again straight after an item");

  // The shared units must be idle whenever a new item may enter.
  a_units_idle: assert property (@(posedge clk) disable iff (rst)
    in_ch.ready |-> (!dp_status.cordic_busy && !dp_status.div_busy))
    else $error("input ready while CORDIC or divider still busy");

  // A fresh result only appears at the end of the computation, never from idle.
  a_result_after_work: assert property (@(posedge clk) disable iff (rst)
    $rose(out_ch.valid) |-> $past(!in_ch.ready))
    else $error("result raised without a computation behind it");

endmodule
